// ----- rtl/vrlo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlo_pkg
// Shared constants, register indexes and controller/datapath link types for
// the voxel ray log-odds update unit.
// ----------------------------------------------------------------------------
package vrlo_pkg;

  localparam int GRID_ENTRIES = 262144;
  localparam int MAX_STEPS    = 1024;
  localparam int LOG_WIDTH    = 16;

  // configuration register indexes
  localparam logic [2:0] REG_STEP     = 3'd0;
  localparam logic [2:0] REG_INV_SIZE = 3'd1;
  localparam logic [2:0] REG_DIM_X    = 3'd2;
  localparam logic [2:0] REG_DIM_Y    = 3'd3;
  localparam logic [2:0] REG_DIM_Z    = 3'd4;
  localparam logic [2:0] REG_LIMIT    = 3'd5;
  localparam logic [2:0] REG_HIT_INC  = 3'd6;
  localparam logic [2:0] REG_MISS_INC = 3'd7;

  localparam logic [15:0]        RST_STEP     = 16'd64;
  localparam logic [15:0]        RST_INV_SIZE = 16'd2560;
  localparam logic [12:0]        RST_DIM      = 13'd64;
  localparam logic [13:0]        RST_LIMIT    = 14'd20;
  localparam logic signed [13:0] RST_HIT_INC  = 14'sd1;
  localparam logic signed [13:0] RST_MISS_INC = -14'sd1;

  // iteration counts of the multi-cycle units
  localparam int SQ_CYC   = 6;   // two partial products per axis
  localparam int ROOT_CYC = 25;  // one root bit per cycle over a 50-bit square
  localparam int DIV_CYC  = 41;  // one quotient bit per cycle

  localparam int CNT_W = 6;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       sq;
    logic       root;
    logic       div_ld;
    logic       div_it;
    logic       div_st;
    logic       adv;
    logic       mul;
    logic       vox;
    logic       idx;
    logic       adr;
    logic       rd;
    logic       upd;
    logic       out_load;
    logic       hit_ph;
    logic [1:0] axis;
    logic       chunk;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic short_ray;
    logic adv_over;
    logic in_grid;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/vrlo_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlo_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vrlo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/vrlo_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlo_ctrl
// Sequencer: store clearing, square and root, per-axis divide, then the
// per-sample read-modify-write loop and the endpoint update.
// ----------------------------------------------------------------------------
module vrlo_ctrl #(
  parameter int MAX_STEPS = vrlo_pkg::MAX_STEPS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vrlo_pkg::sts_t  sts_i,
  output vrlo_pkg::cmd_t  cmd_o
);

  localparam int KW = $clog2(MAX_STEPS + 1);
  localparam int CW = vrlo_pkg::CNT_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ROOT  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_DLD   = 4'd5;
  localparam logic [3:0] S_DIT   = 4'd6;
  localparam logic [3:0] S_DST   = 4'd7;
  localparam logic [3:0] S_ADV   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_VOX   = 4'd10;
  localparam logic [3:0] S_IDX   = 4'd11;
  localparam logic [3:0] S_ADR   = 4'd12;
  localparam logic [3:0] S_RD    = 4'd13;
  localparam logic [3:0] S_UPD   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    axis_q, axis_d;
  logic [KW-1:0] k_q, k_d;
  logic          hit_ph_q, hit_ph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      axis_q   <= '0;
      k_q      <= '0;
      hit_ph_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      axis_q   <= axis_d;
      k_q      <= k_d;
      hit_ph_q <= hit_ph_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    axis_d   = axis_q;
    k_d      = k_q;
    hit_ph_d = hit_ph_q;
    cmd_o        = '0;
    cmd_o.hit_ph = hit_ph_q;
    cmd_o.axis   = axis_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d    = '0;
          k_d      = '0;
          hit_ph_d = 1'b0;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq    = 1'b1;
        cmd_o.axis  = cnt_q[2:1];
        cmd_o.chunk = cnt_q[0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(vrlo_pkg::SQ_CYC - 1)) begin
          cnt_d   = '0;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.root = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(vrlo_pkg::ROOT_CYC - 1)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        axis_d = '0;
        if (sts_i.short_ray) begin
          hit_ph_d = 1'b1;
          state_d  = S_MUL;
        end else begin
          state_d = S_DLD;
        end
      end
      S_DLD: begin
        cmd_o.div_ld = 1'b1;
        cnt_d   = '0;
        state_d = S_DIT;
      end
      S_DIT: begin
        cmd_o.div_it = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(vrlo_pkg::DIV_CYC - 1)) begin
          state_d = S_DST;
        end
      end
      S_DST: begin
        cmd_o.div_st = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = S_ADV;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_DLD;
        end
      end
      S_ADV: begin
        // step bound or end of ray: go on to the endpoint
        if (k_q == KW'(MAX_STEPS) || sts_i.adv_over) begin
          hit_ph_d = 1'b1;
        end else begin
          cmd_o.adv = 1'b1;
          k_d = k_q + 1'b1;
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_VOX;
      end
      S_VOX: begin
        cmd_o.vox = 1'b1;
        state_d   = S_IDX;
      end
      S_IDX: begin
        cmd_o.idx = 1'b1;
        state_d   = S_ADR;
      end
      S_ADR: begin
        cmd_o.adr = 1'b1;
        state_d   = S_RD;
      end
      S_RD: begin
        if (sts_i.in_grid) begin
          cmd_o.rd = 1'b1;
          state_d  = S_UPD;
        end else if (hit_ph_q) begin
          state_d = S_OUT;
        end else begin
          hit_ph_d = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = hit_ph_q ? S_OUT : S_ADV;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

// ----- rtl/vrlo_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrlo_dp
// Datapath: configuration registers, ray length root, incremental sample
// offsets, voxel index pipeline, log-odds store and output word register.
// ----------------------------------------------------------------------------
module vrlo_dp #(
  parameter int GRID_ENTRIES = vrlo_pkg::GRID_ENTRIES,
  parameter int MAX_STEPS    = vrlo_pkg::MAX_STEPS,
  parameter int LOG_WIDTH    = vrlo_pkg::LOG_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic signed [23:0]  origin_x_i,
  input  logic signed [23:0]  origin_y_i,
  input  logic signed [23:0]  origin_z_i,
  input  logic signed [23:0]  hit_x_i,
  input  logic signed [23:0]  hit_y_i,
  input  logic signed [23:0]  hit_z_i,
  input  vrlo_pkg::cmd_t      cmd_i,
  output vrlo_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [10:0]         free_count_o,
  output logic                hit_in_range_o,
  output logic signed [15:0]  hit_value_o,
  output logic                hit_occupied_o
);

  localparam int AW  = $clog2(GRID_ENTRIES);
  localparam int FCW = $clog2(MAX_STEPS + 1);
  localparam logic signed [33:0] V_HI = 34'((longint'(1) << (LOG_WIDTH - 1)) - 1);
  localparam logic signed [33:0] V_LO = -V_HI - 34'sd1;

  // configuration
  logic [15:0]        step_q, inv_q;
  logic [12:0]        dimx_q, dimy_q, dimz_q;
  logic [13:0]        lim_q;
  logic signed [13:0] hinc_q, minc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= vrlo_pkg::RST_STEP;
      inv_q  <= vrlo_pkg::RST_INV_SIZE;
      dimx_q <= vrlo_pkg::RST_DIM;
      dimy_q <= vrlo_pkg::RST_DIM;
      dimz_q <= vrlo_pkg::RST_DIM;
      lim_q  <= vrlo_pkg::RST_LIMIT;
      hinc_q <= vrlo_pkg::RST_HIT_INC;
      minc_q <= vrlo_pkg::RST_MISS_INC;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vrlo_pkg::REG_STEP:     step_q <= cfg_data_i;
        vrlo_pkg::REG_INV_SIZE: inv_q  <= cfg_data_i;
        vrlo_pkg::REG_DIM_X:    dimx_q <= cfg_data_i[12:0];
        vrlo_pkg::REG_DIM_Y:    dimy_q <= cfg_data_i[12:0];
        vrlo_pkg::REG_DIM_Z:    dimz_q <= cfg_data_i[12:0];
        vrlo_pkg::REG_LIMIT:    lim_q  <= cfg_data_i[13:0];
        vrlo_pkg::REG_HIT_INC:  hinc_q <= $signed(cfg_data_i[13:0]);
        vrlo_pkg::REG_MISS_INC: minc_q <= $signed(cfg_data_i[13:0]);
        default: ;
      endcase
    end
  end

  // ray set-up
  logic signed [23:0] org_c [3];
  logic signed [23:0] hin_c [3];
  logic signed [24:0] dif_c [3];
  logic [24:0]        mag_c [3];

  assign org_c[0] = origin_x_i;
  assign org_c[1] = origin_y_i;
  assign org_c[2] = origin_z_i;
  assign hin_c[0] = hit_x_i;
  assign hin_c[1] = hit_y_i;
  assign hin_c[2] = hit_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dif_c[a] = 25'(org_c[a]) - 25'(hin_c[a]);
      mag_c[a] = dif_c[a][24] ? 25'(-dif_c[a]) : 25'(dif_c[a]);
    end
  end

  logic signed [23:0] hit_q  [3];
  logic [24:0]        mag_q  [3];
  logic               neg_q  [3];
  logic [25:0]        q0_q   [3];
  logic [24:0]        r0_q   [3];
  logic [25:0]        offq_q [3];
  logic [24:0]        offr_q [3];
  logic signed [43:0] prod_q [3];
  logic [25:0]        dyz_q;
  logic [49:0]        sq_q;
  logic [27:0]        rem_q;
  logic [24:0]        len_q;
  logic [40:0]        dvd_q;
  logic [24:0]        drem_q;
  logic [25:0]        dist_q;

  // square, one 25x13 partial product per cycle
  logic [24:0] sq_mag;
  logic [12:0] sq_mul;
  logic [37:0] sq_part;
  logic [49:0] sq_add;

  assign sq_mag  = mag_q[cmd_i.axis];
  assign sq_mul  = cmd_i.chunk ? {1'b0, sq_mag[24:13]} : sq_mag[12:0];
  assign sq_part = sq_mag * sq_mul;
  assign sq_add  = cmd_i.chunk ? {sq_part[36:0], 13'b0} : 50'(sq_part);

  // root, one bit per cycle
  logic [27:0] rt_sh, rt_trial;
  logic        rt_ge;

  assign rt_sh    = {rem_q[25:0], sq_q[49:48]};
  assign rt_trial = {1'b0, len_q, 2'b01};
  assign rt_ge    = rt_sh >= rt_trial;

  // divide, one quotient bit per cycle
  logic [40:0] dv_load;
  logic [25:0] dv_rem;
  logic        dv_ge;

  assign dv_load = 41'(step_q * mag_q[cmd_i.axis]);
  assign dv_rem  = {drem_q, dvd_q[40]};
  assign dv_ge   = dv_rem >= {1'b0, len_q};

  // sample advance: offset = floor(dist * mag / len) kept as quotient and remainder
  logic [25:0] ad_rs   [3];
  logic        ad_c    [3];
  logic [25:0] dist_nx;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ad_rs[a] = {1'b0, offr_q[a]} + {1'b0, r0_q[a]};
      ad_c[a]  = ad_rs[a] >= {1'b0, len_q};
    end
  end

  assign dist_nx = dist_q + 26'(step_q);

  // sample point times reciprocal voxel size
  logic signed [26:0] pt_c   [3];
  logic signed [43:0] prod_c [3];
  logic signed [16:0] inv_s;

  assign inv_s = $signed({1'b0, inv_q});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (cmd_i.hit_ph) begin
        pt_c[a] = 27'(hit_q[a]);
      end else if (neg_q[a]) begin
        pt_c[a] = 27'(hit_q[a]) - $signed({1'b0, offq_q[a]});
      end else begin
        pt_c[a] = 27'(hit_q[a]) + $signed({1'b0, offq_q[a]});
      end
      prod_c[a] = pt_c[a] * inv_s;
    end
  end

  // voxel coordinate = ceil(prod / 65536)
  logic signed [43:0] vt_c  [3];
  logic [12:0]        dim_c [3];
  logic               ok_c  [3];
  logic [12:0]        crd_q [3];
  logic               vok_q;

  assign dim_c[0] = dimx_q;
  assign dim_c[1] = dimy_q;
  assign dim_c[2] = dimz_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vt_c[a] = (prod_q[a] + 44'sd65535) >>> 16;
      ok_c[a] = !vt_c[a][43] && (vt_c[a][42:0] < 43'(dim_c[a]));
    end
  end

  // linear index
  logic [38:0]   pa_q;
  logic [25:0]   pb_q;
  logic [12:0]   pz_q;
  logic          iok_q;
  logic [39:0]   sum_c;
  logic [AW-1:0] addr_q;
  logic          ing_q;

  assign sum_c = 40'(pa_q) + 40'(pb_q) + 40'(pz_q);

  // store and update
  logic [AW-1:0]          clr_q;
  logic [LOG_WIDTH-1:0]   rdata;
  logic signed [33:0]     v34, inc34, lim34, sum34, nv34, res34;
  logic                   upd_ok;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [LOG_WIDTH-1:0]   ram_wdata;
  logic signed [15:0]     res16;

  always_comb begin
    v34   = 34'($signed(rdata));
    inc34 = cmd_i.hit_ph ? 34'(hinc_q) : 34'(minc_q);
    lim34 = $signed({20'b0, lim_q});
    upd_ok = (v34 > -lim34) && (v34 < lim34);
    sum34 = v34 + inc34;
    if (sum34 > V_HI) begin
      nv34 = V_HI;
    end else if (sum34 < V_LO) begin
      nv34 = V_LO;
    end else begin
      nv34 = sum34;
    end
    res34 = upd_ok ? nv34 : v34;
    if (res34 > 34'sd32767) begin
      res16 = 16'sd32767;
    end else if (res34 < -34'sd32768) begin
      res16 = -16'sd32768;
    end else begin
      res16 = res34[15:0];
    end
  end

  assign ram_we    = cmd_i.clear || (cmd_i.upd && upd_ok);
  assign ram_waddr = cmd_i.clear ? clr_q : addr_q;
  assign ram_wdata = cmd_i.clear ? '0 : nv34[LOG_WIDTH-1:0];

  vrlo_ram #(
    .WIDTH (LOG_WIDTH),
    .DEPTH (GRID_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  logic [FCW-1:0]     fc_q;
  logic               hin_q;
  logic signed [15:0] hv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int a = 0; a < 3; a++) begin
        hit_q[a]  <= hin_c[a];
        mag_q[a]  <= mag_c[a];
        neg_q[a]  <= dif_c[a][24];
        offq_q[a] <= '0;
        offr_q[a] <= '0;
      end
      dyz_q  <= dimy_q * dimz_q;
      sq_q   <= '0;
      rem_q  <= '0;
      len_q  <= '0;
      dist_q <= '0;
      fc_q   <= '0;
      hin_q  <= 1'b0;
      hv_q   <= '0;
    end
    if (cmd_i.sq) begin
      sq_q <= sq_q + sq_add;
    end
    if (cmd_i.root) begin
      rem_q <= rt_ge ? rt_sh - rt_trial : rt_sh;
      len_q <= {len_q[23:0], rt_ge};
      sq_q  <= {sq_q[47:0], 2'b00};
    end
    if (cmd_i.div_ld) begin
      dvd_q  <= dv_load;
      drem_q <= '0;
    end
    if (cmd_i.div_it) begin
      drem_q <= dv_ge ? 25'(dv_rem - {1'b0, len_q}) : dv_rem[24:0];
      dvd_q  <= {dvd_q[39:0], dv_ge};
    end
    if (cmd_i.div_st) begin
      q0_q[cmd_i.axis] <= dvd_q[25:0];
      r0_q[cmd_i.axis] <= drem_q;
    end
    if (cmd_i.adv) begin
      dist_q <= dist_nx;
      for (int a = 0; a < 3; a++) begin
        offr_q[a] <= ad_c[a] ? 25'(ad_rs[a] - {1'b0, len_q}) : ad_rs[a][24:0];
        offq_q[a] <= offq_q[a] + q0_q[a] + 26'(ad_c[a]);
      end
    end
    if (cmd_i.mul) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= prod_c[a];
      end
    end
    if (cmd_i.vox) begin
      for (int a = 0; a < 3; a++) begin
        crd_q[a] <= vt_c[a][12:0];
      end
      vok_q <= ok_c[0] && ok_c[1] && ok_c[2];
    end
    if (cmd_i.idx) begin
      pa_q  <= crd_q[0] * dyz_q;
      pb_q  <= crd_q[1] * dimz_q;
      pz_q  <= crd_q[2];
      iok_q <= vok_q;
    end
    if (cmd_i.adr) begin
      addr_q <= sum_c[AW-1:0];
      ing_q  <= iok_q && (sum_c < 40'(GRID_ENTRIES));
    end
    if (cmd_i.upd) begin
      if (cmd_i.hit_ph) begin
        hin_q <= 1'b1;
        hv_q  <= res16;
      end else begin
        fc_q <= fc_q + 1'b1;
      end
    end
  end

  // output word register
  logic                   out_valid_q;
  logic [10:0]            fc_out_q;
  logic                   hin_out_q;
  logic signed [15:0]     hv_out_q;
  logic                   occ_out_q;
  logic [FCW+10:0]        fc_ext;

  assign fc_ext = (FCW + 11)'(fc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      fc_out_q  <= fc_ext[10:0];
      hin_out_q <= hin_q;
      hv_out_q  <= hv_q;
      occ_out_q <= hv_q > 16'sd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign free_count_o   = fc_out_q;
  assign hit_in_range_o = hin_out_q;
  assign hit_value_o    = hv_out_q;
  assign hit_occupied_o = occ_out_q;

  assign sts_o.clear_last = (clr_q == AW'(GRID_ENTRIES - 1));
  assign sts_o.short_ray  = (step_q == 16'd0) || (len_q < 25'(step_q));
  assign sts_o.adv_over   = dist_nx > 26'(len_q);
  assign sts_o.in_grid    = ing_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ----- rtl/voxel_ray_log_odds_update_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_log_odds_update_unit
// Marches one sensor ray through a 3-D log-odds occupancy grid, applying
// free-space updates along the ray and a hit update at the endpoint.
// ----------------------------------------------------------------------------
// Timing per ray: the 25-step root and, unless the step is zero or exceeds the
//   ray length, three 41-step divides, then a sequential read-modify-write of
//   the store for each free-space sample taken and for an endpoint in the grid.
// Throughput: one ray at a time; the next word is taken once the result has
//   moved to the output register.
// Reset: the store is swept to zero entry by entry; no word is taken until then.
module voxel_ray_log_odds_update_unit #(
  parameter int GRID_ENTRIES = vrlo_pkg::GRID_ENTRIES,
  parameter int MAX_STEPS    = vrlo_pkg::MAX_STEPS,
  parameter int LOG_WIDTH    = vrlo_pkg::LOG_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] origin_x_i,
  input  logic signed [23:0] origin_y_i,
  input  logic signed [23:0] origin_z_i,
  input  logic signed [23:0] hit_x_i,
  input  logic signed [23:0] hit_y_i,
  input  logic signed [23:0] hit_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [10:0]        free_count_o,
  output logic               hit_in_range_o,
  output logic signed [15:0] hit_value_o,
  output logic               hit_occupied_o
);

  vrlo_pkg::cmd_t cmd;
  vrlo_pkg::sts_t sts;

  vrlo_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vrlo_dp #(
    .GRID_ENTRIES (GRID_ENTRIES),
    .MAX_STEPS    (MAX_STEPS),
    .LOG_WIDTH    (LOG_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .origin_z_i     (origin_z_i),
    .hit_x_i        (hit_x_i),
    .hit_y_i        (hit_y_i),
    .hit_z_i        (hit_z_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .free_count_o   (free_count_o),
    .hit_in_range_o (hit_in_range_o),
    .hit_value_o    (hit_value_o),
    .hit_occupied_o (hit_occupied_o)
  );

endmodule

// ----- tb/sv/tb_voxel_ray_log_odds_update_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_ray_log_odds_update_unit
// Self-checking bench for the voxel ray log-odds update unit. A behavioural
// copy of the grid store is updated for every accepted ray and the expected
// free count and endpoint value are compared with each result word. The run
// covers directed rays and register extremes, back-pressure and random
// rays under several register settings.
// ----------------------------------------------------------------------------
module tb_voxel_ray_log_odds_update_unit;

  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    int unsigned free_cnt;
    bit          in_range;
    int          value;
    bit          occupied;
  } ray_result_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [2:0]         cfg_idx    = '0;
  logic [15:0]        cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic signed [23:0] origin_x   = '0;
  logic signed [23:0] origin_y   = '0;
  logic signed [23:0] origin_z   = '0;
  logic signed [23:0] hit_x      = '0;
  logic signed [23:0] hit_y      = '0;
  logic signed [23:0] hit_z      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [10:0]        free_count;
  logic               hit_in_range;
  logic signed [15:0] hit_value;
  logic               hit_occupied;

  voxel_ray_log_odds_update_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .origin_x_i    (origin_x),
    .origin_y_i    (origin_y),
    .origin_z_i    (origin_z),
    .hit_x_i       (hit_x),
    .hit_y_i       (hit_y),
    .hit_z_i       (hit_z),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .free_count_o  (free_count),
    .hit_in_range_o(hit_in_range),
    .hit_value_o   (hit_value),
    .hit_occupied_o(hit_occupied)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow grid and registers
  int          occ_grid [vrlo_pkg::GRID_ENTRIES];
  int unsigned cfg_step = vrlo_pkg::RST_STEP;
  int unsigned cfg_inv  = vrlo_pkg::RST_INV_SIZE;
  int unsigned cfg_dim [3] = '{vrlo_pkg::RST_DIM, vrlo_pkg::RST_DIM, vrlo_pkg::RST_DIM};
  longint      cfg_lim      = vrlo_pkg::RST_LIMIT;
  longint      cfg_hit_inc  = vrlo_pkg::RST_HIT_INC;
  longint      cfg_miss_inc = vrlo_pkg::RST_MISS_INC;

  ray_result_t pending_q[$];
  int          errors       = 0;
  int          rays_sent    = 0;
  int          words_seen   = 0;
  longint      free_total   = 0;
  int          hits_inside  = 0;
  int          send_gap_max = 9;
  bit          rx_quiet     = 1'b0;
  int          long_hold    = 0;
  longint      cycles       = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // ceil of p * inv / 65536, rounding toward zero for non-positive products
  function automatic longint voxel_coord(longint p);
    longint prod;
    prod = p * longint'(cfg_inv);
    if (prod > 0) return (prod + 65535) / 65536;
    return -((-prod) / 65536);
  endfunction

  function automatic bit grid_index(longint p [3], output longint idx);
    longint v [3];
    idx = 0;
    for (int a = 0; a < 3; a++) begin
      v[a] = voxel_coord(p[a]);
      if (v[a] < 0 || v[a] >= longint'(cfg_dim[a])) return 1'b0;
    end
    idx = v[0] * cfg_dim[1] * cfg_dim[2] + v[1] * cfg_dim[2] + v[2];
    return idx < vrlo_pkg::GRID_ENTRIES;
  endfunction

  function automatic void bump_voxel(longint idx, longint inc);
    longint v;
    v = occ_grid[idx];
    if (v > -cfg_lim && v < cfg_lim) begin
      v += inc;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      occ_grid[idx] = int'(v);
    end
  endfunction

  function automatic ray_result_t trace_ray(longint org [3], longint hit [3]);
    ray_result_t     res;
    longint          d [3];
    longint          p [3];
    longint unsigned sq, len, march, mag, off;
    longint          idx;
    res = '{0, 1'b0, 0, 1'b0};
    sq = 0;
    for (int a = 0; a < 3; a++) begin
      d[a] = org[a] - hit[a];
      sq += longint'(d[a] * d[a]);
    end
    len = int_sqrt(sq);
    march = 0;
    if (cfg_step != 0 && len >= cfg_step) begin
      for (int k = 0; k < vrlo_pkg::MAX_STEPS; k++) begin
        march += cfg_step;
        if (march > len) break;
        for (int a = 0; a < 3; a++) begin
          mag = (d[a] < 0) ? longint'(-d[a]) : longint'(d[a]);
          off = (march * mag) / len;
          p[a] = hit[a] + ((d[a] < 0) ? -longint'(off) : longint'(off));
        end
        if (!grid_index(p, idx)) break;
        bump_voxel(idx, cfg_miss_inc);
        res.free_cnt++;
      end
    end
    if (grid_index(hit, idx)) begin
      bump_voxel(idx, cfg_hit_inc);
      res.in_range = 1'b1;
      res.value    = occ_grid[idx];
      res.occupied = occ_grid[idx] > 0;
    end
    return res;
  endfunction

  // cycle guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result checker and output stall generator
  int hold_left = 0;
  always @(posedge clk_i) begin
    ray_result_t want;
    bit          took;
    took = out_valid && !out_stall;
    if (took) begin
      words_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (free_count != want.free_cnt) begin
          $error("free_count expected %0d actual %0d", want.free_cnt, free_count);
          errors++;
        end
        if (hit_in_range != want.in_range) begin
          $error("hit_in_range expected %0d actual %0d", want.in_range, hit_in_range);
          errors++;
        end
        if (int'(hit_value) != want.value) begin
          $error("hit_value expected %0d actual %0d", want.value, hit_value);
          errors++;
        end
        if (hit_occupied != want.occupied) begin
          $error("hit_occupied expected %0d actual %0d", want.occupied, hit_occupied);
          errors++;
        end
      end
    end
    if (long_hold > 0) begin
      hold_left = long_hold;
      long_hold = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (took && !rx_quiet) begin
      hold_left = $urandom_range(0, 9);
      out_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_ray(longint ox, longint oy, longint oz,
                          longint hx, longint hy, longint hz);
    int     gap;
    longint org [3];
    longint hit [3];
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    origin_x <= ox[23:0];
    origin_y <= oy[23:0];
    origin_z <= oz[23:0];
    hit_x    <= hx[23:0];
    hit_y    <= hy[23:0];
    hit_z    <= hz[23:0];
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    // predict from the word as the block sees it
    org = '{longint'(origin_x), longint'(origin_y), longint'(origin_z)};
    hit = '{longint'(hit_x), longint'(hit_y), longint'(hit_z)};
    pending_q.push_back(trace_ray(org, hit));
    free_total += pending_q[$].free_cnt;
    hits_inside += pending_q[$].in_range;
    rays_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      vrlo_pkg::REG_STEP:     cfg_step     = val;
      vrlo_pkg::REG_INV_SIZE: cfg_inv      = val;
      vrlo_pkg::REG_DIM_X:    cfg_dim[0]   = val[12:0];
      vrlo_pkg::REG_DIM_Y:    cfg_dim[1]   = val[12:0];
      vrlo_pkg::REG_DIM_Z:    cfg_dim[2]   = val[12:0];
      vrlo_pkg::REG_LIMIT:    cfg_lim      = val[13:0];
      vrlo_pkg::REG_HIT_INC:  cfg_hit_inc  = longint'($signed(val[13:0]));
      vrlo_pkg::REG_MISS_INC: cfg_miss_inc = longint'($signed(val[13:0]));
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned step, int unsigned inv, int unsigned dx,
                            int unsigned dy, int unsigned dz, int unsigned lim,
                            int hinc, int minc);
    wait_drained();
    write_reg(vrlo_pkg::REG_STEP, step[15:0]);
    write_reg(vrlo_pkg::REG_INV_SIZE, inv[15:0]);
    write_reg(vrlo_pkg::REG_DIM_X, dx[15:0]);
    write_reg(vrlo_pkg::REG_DIM_Y, dy[15:0]);
    write_reg(vrlo_pkg::REG_DIM_Z, dz[15:0]);
    write_reg(vrlo_pkg::REG_LIMIT, lim[15:0]);
    write_reg(vrlo_pkg::REG_HIT_INC, hinc[15:0]);
    write_reg(vrlo_pkg::REG_MISS_INC, minc[15:0]);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // random rays shaped to the current grid: most start near it and stay short
  task automatic run_phase(int n);
    longint ext [3];
    longint h [3];
    longint o [3];
    longint reach;
    reach = longint'(cfg_step) * 20;
    if (reach < 8) reach = 8;
    if (reach > (1 << 22)) reach = 1 << 22;
    for (int a = 0; a < 3; a++) begin
      ext[a] = longint'(cfg_dim[a]) * 65536 / cfg_inv;
      if (ext[a] < 1) ext[a] = 1;
      if (ext[a] > (1 << 22)) ext[a] = 1 << 22;
    end
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_ray(longint'($signed(24'($urandom()))),
                 longint'($signed(24'($urandom()))),
                 longint'($signed(24'($urandom()))),
                 longint'($signed(24'($urandom()))),
                 longint'($signed(24'($urandom()))),
                 longint'($signed(24'($urandom()))));
      end else begin
        for (int a = 0; a < 3; a++) begin
          h[a] = clip24(pick(-ext[a] / 8 - 1, ext[a] + ext[a] / 8));
          o[a] = clip24(h[a] + pick(-reach, reach));
        end
        send_ray(o[0], o[1], o[2], h[0], h[1], h[2]);
      end
    end
  endtask

  task automatic test_directed();
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(1600, 1200, 400, 800, 800, 800);
    send_ray(8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    send_ray(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
    send_ray(130, 100, 100, 100, 100, 100);
    send_ray(-8388608, -8388608, -8388608, 900, 700, 300);
    send_ray(8388607, -8388608, 8388607, 300, 1200, 60);
    // extreme increments, then frozen voxels
    set_config(64, 2560, 64, 64, 64, 20, 8191, -8192);
    repeat (3) send_ray(900, 500, 500, 500, 500, 500);
    // zero step leaves only the endpoint
    set_config(0, 2560, 64, 64, 64, 20, 1, -1);
    send_ray(1500, 1500, 1500, 10, 10, 10);
    // empty grid
    set_config(64, 2560, 0, 64, 64, 20, 1, -1);
    send_ray(1500, 1500, 1500, 10, 10, 10);
    // huge voxels and unit step: the march runs into the step bound
    set_config(1, 1, 64, 64, 64, 20, 1, -1);
    send_ray(1, 1, 3000, 1, 1, 1);
    // zero limit freezes everything
    set_config(64, 65535, 4096, 64, 64, 0, 5, -5);
    send_ray(1000, 40, 40, 20, 20, 20);
    // large grid: indexes past the store count as outside
    set_config(64, 2560, 4096, 4096, 4096, 16383, -8192, 8191);
    send_ray(0, 0, 0, 0, 0, 5000);
    send_ray(0, 0, 0, 100, 0, 0);
    set_config(vrlo_pkg::RST_STEP, vrlo_pkg::RST_INV_SIZE, vrlo_pkg::RST_DIM,
               vrlo_pkg::RST_DIM, vrlo_pkg::RST_DIM, vrlo_pkg::RST_LIMIT, 1, -1);
  endtask

  task automatic test_backpressure();
    send_gap_max = 0;
    long_hold = 3000;
    repeat (8) send_ray(pick(0, 1600), pick(0, 1600), pick(0, 1600),
                        pick(0, 1600), pick(0, 1600), pick(0, 1600));
    send_gap_max = 9;
    // pause until every result is back, then carry on
    wait_drained();
    run_phase(20);
  endtask

  task automatic test_random();
    rx_quiet = 1'b0;
    run_phase(140);
    set_config($urandom_range(1, 16), 2560, 64, 64, 64, 5, 3, -2);
    rx_quiet = 1'b1;
    send_gap_max = 0;
    run_phase(140);
    rx_quiet = 1'b0;
    send_gap_max = 9;
    set_config(65535, 65535, 4096, 4096, 4096, 16383, 8191, -8192);
    run_phase(140);
    set_config(200, 1000, 1, 3, 2, 0, -8192, 8191);
    run_phase(100);
    repeat (2) begin
      set_config($urandom_range(16, 512), $urandom_range(256, 8000),
                 $urandom_range(1, 80), $urandom_range(1, 80), $urandom_range(1, 80),
                 $urandom_range(1, 60), int'(pick(-50, 50)), int'(pick(-50, 50)));
      run_phase(140);
    end
    set_config(64, 2560, 13, 64, 200, 30, 4, -1);
    run_phase(100);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("%0d rays sent, %0d result words checked", rays_sent, words_seen);
    $display("%0d free-space updates predicted, %0d endpoints inside the grid",
             free_total, hits_inside);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
